[sv/lswc_pkg.sv]
// Shared types, constants and the color wheel step function for the LED strip wipe controller.
`default_nettype none
package lswc_pkg;

    // Field widths
    localparam int unsigned LIGHT_W = 10;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned START_W = 6;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Thresholds and step sizes
    localparam logic [LIGHT_W-1:0] LIGHT_DARK_MAX   = 10'd20;
    localparam logic [LIGHT_W-1:0] LIGHT_BRIGHT_MIN = 10'd100;
    localparam logic [TIMER_W-1:0] STEP_DELAY_INIT  = 16'd10;
    localparam logic [TIMER_W-1:0] STEP_DELAY_INC   = 16'd5;
    localparam logic [TIMER_W-1:0] STEP_DELAY_CAP   = 16'd65530;
    localparam logic [TIMER_W-1:0] TIMER_MAX        = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_MAX        = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_RED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_GREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_BLUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_PERIOD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_PERIOD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_STEP_DELAY  = 3'd7;

    // Configuration register reset values
    localparam logic [START_W-1:0] SLOWDOWN_START_RST  = 6'd40;
    localparam logic [TIMER_W-1:0] SLOWDOWN_PERIOD_RST = 16'd30;
    localparam logic [TIMER_W-1:0] OFF_STEP_DELAY_RST  = 16'd5;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb               custom;
        logic               color_mode;
        logic [TIMER_W-1:0] fade_period;
        logic [START_W-1:0] slowdown_start;
        logic [TIMER_W-1:0] slowdown_period;
        logic [TIMER_W-1:0] off_step_delay;
    } t_cfg;

    typedef struct packed {
        logic [LIGHT_W-1:0] light_level;
        logic               pc_on;
        logic               touch;
        logic               auto_enable;
    } t_tick;

    typedef struct packed {
        logic [COUNT_W-1:0] lit_count;
        t_rgb               pixel;
        logic               relay_on;
        logic               strip_on;
    } t_result;

    // Saturating millisecond timer increment
    function automatic logic [TIMER_W-1:0] timer_inc(input logic [TIMER_W-1:0] t);
        timer_inc = (t == TIMER_MAX) ? t : t + 16'd1;
    endfunction

    // One step along the six-phase wheel; off the path the color holds
    function automatic t_rgb wheel_step(input t_rgb c);
        t_rgb n;
        n = c;
        if (c.red == COLOR_MAX && c.green != COLOR_MAX && c.blue == '0) begin
            n.green = c.green + 8'd1;
        end else if (c.red != '0 && c.green == COLOR_MAX && c.blue == '0) begin
            n.red = c.red - 8'd1;
        end else if (c.red == '0 && c.green == COLOR_MAX && c.blue != COLOR_MAX) begin
            n.blue = c.blue + 8'd1;
        end else if (c.red == '0 && c.green != '0 && c.blue == COLOR_MAX) begin
            n.green = c.green - 8'd1;
        end else if (c.red != COLOR_MAX && c.green == '0 && c.blue == COLOR_MAX) begin
            n.red = c.red + 8'd1;
        end else if (c.red == COLOR_MAX && c.green == '0 && c.blue != '0) begin
            n.blue = c.blue - 8'd1;
        end
        wheel_step = n;
    endfunction

endpackage
`default_nettype wire

[sv/lswc_cfg_regs.sv]
// Configuration register file for the LED strip wipe controller.
`default_nettype none
module lswc_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [lswc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lswc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lswc_pkg::t_cfg                          o_cfg
);

    lswc_pkg::t_cfg r_cfg;

    // Register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.custom.red      <= '0;
            r_cfg.custom.green    <= '0;
            r_cfg.custom.blue     <= '0;
            r_cfg.color_mode      <= 1'b0;
            r_cfg.fade_period     <= '0;
            r_cfg.slowdown_start  <= lswc_pkg::SLOWDOWN_START_RST;
            r_cfg.slowdown_period <= lswc_pkg::SLOWDOWN_PERIOD_RST;
            r_cfg.off_step_delay  <= lswc_pkg::OFF_STEP_DELAY_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lswc_pkg::CFG_CUSTOM_RED:      r_cfg.custom.red   <= i_cfg_data[7:0];
                lswc_pkg::CFG_CUSTOM_GREEN:    r_cfg.custom.green <= i_cfg_data[7:0];
                lswc_pkg::CFG_CUSTOM_BLUE:     r_cfg.custom.blue  <= i_cfg_data[7:0];
                lswc_pkg::CFG_COLOR_MODE:      r_cfg.color_mode   <= i_cfg_data[0];
                lswc_pkg::CFG_FADE_PERIOD:     r_cfg.fade_period  <= i_cfg_data;
                lswc_pkg::CFG_SLOWDOWN_START:  r_cfg.slowdown_start <= i_cfg_data[5:0];
                lswc_pkg::CFG_SLOWDOWN_PERIOD: r_cfg.slowdown_period <= i_cfg_data;
                lswc_pkg::CFG_OFF_STEP_DELAY:  r_cfg.off_step_delay <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[sv/lswc_core.sv]
// Per-tick state update: wipe, auto on/off, touch toggle, relay and color wheel.
`default_nettype none
module lswc_core #(
    parameter int unsigned STRIP_LEN = 60
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire lswc_pkg::t_tick i_tick,
    input  wire lswc_pkg::t_cfg  i_cfg,
    output lswc_pkg::t_result    o_result
);

    localparam logic [lswc_pkg::COUNT_W-1:0] LEN = lswc_pkg::COUNT_W'(STRIP_LEN);

    // Tick state; lit count is the lit index plus one (zero means all dark)
    logic                              r_on;
    logic                              r_was_on;
    logic [lswc_pkg::COUNT_W-1:0]      r_cnt;
    logic [lswc_pkg::TIMER_W-1:0]      r_delay;
    logic [lswc_pkg::TIMER_W-1:0]      r_step_t;
    logic [lswc_pkg::TIMER_W-1:0]      r_slow_t;
    logic [lswc_pkg::TIMER_W-1:0]      r_fade_t;
    logic                              r_armed_off;
    logic                              r_off_latched;
    lswc_pkg::t_rgb                    r_wheel;
    logic                              r_relay;

    logic                              n_on;
    logic                              n_was_on;
    logic [lswc_pkg::COUNT_W-1:0]      n_cnt;
    logic [lswc_pkg::TIMER_W-1:0]      n_delay;
    logic [lswc_pkg::TIMER_W-1:0]      n_step_t;
    logic [lswc_pkg::TIMER_W-1:0]      n_slow_t;
    logic [lswc_pkg::TIMER_W-1:0]      n_fade_t;
    logic                              n_armed_off;
    logic                              n_off_latched;
    lswc_pkg::t_rgb                    n_wheel;
    logic                              n_relay;
    lswc_pkg::t_rgb                    n_pixel;

    always_comb begin
        n_on          = r_on;
        n_was_on      = r_was_on;
        n_cnt         = r_cnt;
        n_delay       = r_delay;
        n_armed_off   = r_armed_off;
        n_off_latched = r_off_latched;
        n_wheel       = r_wheel;
        n_relay       = r_relay;
        n_step_t      = lswc_pkg::timer_inc(r_step_t);
        n_slow_t      = lswc_pkg::timer_inc(r_slow_t);
        n_fade_t      = lswc_pkg::timer_inc(r_fade_t);

        // Wipe: grow while on, shrink while off
        if (r_on) begin
            if (!r_was_on) begin
                n_cnt    = 6'd1;
                n_delay  = lswc_pkg::STEP_DELAY_INIT;
                n_was_on = 1'b1;
            end
            if (n_step_t >= n_delay) begin
                if (n_cnt < LEN) begin
                    n_cnt = n_cnt + 6'd1;
                end
                n_step_t = '0;
            end
            if (n_slow_t >= i_cfg.slowdown_period) begin
                if (n_cnt > i_cfg.slowdown_start) begin
                    n_delay = (n_delay <= lswc_pkg::STEP_DELAY_CAP)
                            ? n_delay + lswc_pkg::STEP_DELAY_INC : lswc_pkg::TIMER_MAX;
                end
                n_slow_t = '0;
            end
        end else begin
            n_was_on = 1'b0;
            if (n_step_t >= i_cfg.off_step_delay) begin
                if (n_cnt != '0) begin
                    n_cnt = n_cnt - 6'd1;
                end
                n_step_t = '0;
            end
            n_delay = lswc_pkg::STEP_DELAY_INIT;
        end

        // Color drawn this tick, before the wheel moves
        n_pixel = i_cfg.color_mode ? r_wheel : i_cfg.custom;

        // Automatic on/off with latching
        if (i_tick.light_level <= lswc_pkg::LIGHT_DARK_MAX && !r_armed_off && i_tick.pc_on) begin
            if (i_tick.auto_enable) begin
                n_on = 1'b1;
            end
            n_armed_off   = 1'b1;
            n_off_latched = 1'b0;
        end else if ((i_tick.light_level >= lswc_pkg::LIGHT_BRIGHT_MIN || !i_tick.pc_on)
                     && !r_off_latched) begin
            n_on          = 1'b0;
            n_armed_off   = 1'b0;
            n_off_latched = 1'b1;
        end

        // Touch toggle
        if (i_tick.touch && (i_tick.auto_enable || n_on)) begin
            n_on = !n_on;
        end

        // Relay holds until the strip is dark
        if (n_on) begin
            n_relay = 1'b1;
        end else if (n_cnt == '0) begin
            n_relay = 1'b0;
        end

        // Color wheel
        if (n_fade_t >= i_cfg.fade_period && i_cfg.color_mode && n_on) begin
            n_wheel  = lswc_pkg::wheel_step(r_wheel);
            n_fade_t = '0;
        end
    end

    // State update once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on          <= 1'b0;
            r_was_on      <= 1'b0;
            r_cnt         <= '0;
            r_delay       <= lswc_pkg::STEP_DELAY_INIT;
            r_step_t      <= '0;
            r_slow_t      <= '0;
            r_fade_t      <= '0;
            r_armed_off   <= 1'b1;
            r_off_latched <= 1'b0;
            r_wheel.red   <= lswc_pkg::COLOR_MAX;
            r_wheel.green <= '0;
            r_wheel.blue  <= '0;
            r_relay       <= 1'b0;
        end else if (i_adv) begin
            r_on          <= n_on;
            r_was_on      <= n_was_on;
            r_cnt         <= n_cnt;
            r_delay       <= n_delay;
            r_step_t      <= n_step_t;
            r_slow_t      <= n_slow_t;
            r_fade_t      <= n_fade_t;
            r_armed_off   <= n_armed_off;
            r_off_latched <= n_off_latched;
            r_wheel       <= n_wheel;
            r_relay       <= n_relay;
        end
    end

    assign o_result.lit_count = n_cnt;
    assign o_result.pixel     = n_pixel;
    assign o_result.relay_on  = n_relay;
    assign o_result.strip_on  = n_on;

endmodule
`default_nettype wire

[sv/led_strip_wipe_controller.sv]
// LED strip wipe controller: tick input register, state update core and result register.
// A tick word is captured in the input register, then passes through the core into the result register.
// Throughput: one tick word per cycle; the input register and result register
// stall together only when the result waits and the input register is full.
// Reset (synchronous, active low) clears both valid flags and returns the tick state
// (strip off, all dark, step delay 10) and the configuration registers to their defaults.
`default_nettype none
module led_strip_wipe_controller #(
    parameter int unsigned STRIP_LEN = 60
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Tick channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [lswc_pkg::LIGHT_W-1:0]        i_light_level,
    input  wire logic                                i_pc_on,
    input  wire logic                                i_touch,
    input  wire logic                                i_auto_enable,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lswc_pkg::COUNT_W-1:0]             o_lit_count,
    output logic [lswc_pkg::COLOR_W-1:0]             o_pixel_red,
    output logic [lswc_pkg::COLOR_W-1:0]             o_pixel_green,
    output logic [lswc_pkg::COLOR_W-1:0]             o_pixel_blue,
    output logic                                     o_relay_on,
    output logic                                     o_strip_on,
    // Configuration write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lswc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lswc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lswc_pkg::t_cfg    cfg;
    lswc_pkg::t_result core_result;

    logic              r_in_valid;
    lswc_pkg::t_tick   r_tick;
    logic              r_out_valid;
    lswc_pkg::t_result r_result;
    logic              adv;
    logic              in_take;

    // Handshake: a word moves to the result register unless a result is stuck
    assign adv        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    lswc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lswc_core #(
        .STRIP_LEN (STRIP_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_tick   (r_tick),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tick.light_level <= i_light_level;
            r_tick.pc_on       <= i_pc_on;
            r_tick.touch       <= i_touch;
            r_tick.auto_enable <= i_auto_enable;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lit_count   = r_result.lit_count;
    assign o_pixel_red   = r_result.pixel.red;
    assign o_pixel_green = r_result.pixel.green;
    assign o_pixel_blue  = r_result.pixel.blue;
    assign o_relay_on    = r_result.relay_on;
    assign o_strip_on    = r_result.strip_on;

    // Lit count never runs past the strip
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lit_count <= lswc_pkg::COUNT_W'(STRIP_LEN)))
        else $error("lit count beyond strip length");

    // The relay is driven whenever the strip is on
    a_relay_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_strip_on) |-> o_relay_on)
        else $error("strip on without relay");

    // A held tick word stays in the input register
    a_hold_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_tick)))
        else $error("stalled tick word lost");

    // A turn-on with a dark strip still reports zero lit pixels for the tick that turns it on
    a_wipe_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && core_result.strip_on && !r_result.strip_on && r_out_valid
         && r_result.lit_count == '0) |=> (o_lit_count == '0))
        else $error("wipe started before the on edge was seen");

endmodule
`default_nettype wire
